FILE: hdl/ipspc_pkg.sv
package ipspc_pkg;

    // Address family codes, sampled on the first beat of a packet.
    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    localparam int OFFSET_W = 7;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 7'd127;

    // Fixed header offsets.
    localparam logic [OFFSET_W-1:0] OFF_FRAG_HI   = 7'd6;
    localparam logic [OFFSET_W-1:0] OFF_FRAG_LO   = 7'd7;
    localparam logic [OFFSET_W-1:0] OFF_V6_NEXT   = 7'd6;
    localparam logic [OFFSET_W-1:0] OFF_V4_PROTO  = 7'd9;
    localparam logic [OFFSET_W-1:0] OFF_V4_SRC_LO = 7'd12;
    localparam logic [OFFSET_W-1:0] OFF_V4_SRC_HI = 7'd15;
    localparam logic [OFFSET_W-1:0] OFF_V6_SRC0_LO = 7'd8;
    localparam logic [OFFSET_W-1:0] OFF_V6_SRC0_HI = 7'd15;
    localparam logic [OFFSET_W-1:0] OFF_V6_SRC1_LO = 7'd16;
    localparam logic [OFFSET_W-1:0] OFF_V6_SRC1_HI = 7'd23;
    localparam logic [OFFSET_W-1:0] V6_TRANSPORT_BASE = 7'd40;

    // Offsets within the transport header.
    localparam logic [OFFSET_W-1:0] TP_PORT_HI = 7'd2;
    localparam logic [OFFSET_W-1:0] TP_PORT_LO = 7'd3;
    localparam logic [OFFSET_W-1:0] TP_FLAGS   = 7'd13;

    // Length limits.
    localparam logic [OFFSET_W:0] V4_MIN_IHL   = 8'd20;
    localparam logic [OFFSET_W:0] V4_MIN_LEN   = 8'd16;
    localparam logic [OFFSET_W:0] V6_MIN_LEN   = 8'd24;

    localparam logic [3:0]  VERSION_V4 = 4'd4;
    localparam logic [3:0]  VERSION_V6 = 4'd6;

    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;

    localparam logic [7:0]  ICMP_ECHO_REQ   = 8'd8;
    localparam logic [7:0]  ICMPV6_ECHO_REQ = 8'd128;

    localparam logic [7:0]  TCP_SYN_ACK_MASK = 8'h12;
    localparam logic [7:0]  TCP_SYN_ONLY     = 8'h02;
    localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1fff;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
        logic [1:0] family;
    } in_beat_t;

    typedef struct packed {
        logic        hit;
        logic        touch_kind;
        logic [15:0] dest_port;
        logic        source_is_v6;
        logic [63:0] source_high;
        logic [63:0] source_low;
    } result_t;

endpackage

FILE: hdl/ip_syn_ping_classifier_core.sv
// Flow: a beat accepted into the input register is parsed from there; the verdict of
// a last beat is loaded into the result register and presented on out_result.
// Throughput: one beat per cycle, set by the single parse stage between the
// input register and the result register; stalls only when a result waits.
// Reset (rst_n, asynchronous, active low) empties both registers and returns
// the byte offset and all captured header fields to zero.
module ip_syn_ping_classifier_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ipspc_pkg::in_beat_t in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output ipspc_pkg::result_t  out_result
);
    import ipspc_pkg::*;

    logic     sink_free;
    logic     take;
    logic     beat_valid;
    in_beat_t beat;
    result_t  verdict;
    logic     out_valid_reg;
    result_t  out_result_reg;
    logic     load;

    assign sink_free = !out_valid_reg || out_ready;
    assign load      = take && beat.last_byte;

    ipspc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_beat    (in_beat),
        .sink_free  (sink_free),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    ipspc_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .beat    (beat),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sink_free)
        begin
            out_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_result_reg <= verdict;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    // A last beat leaving the input register always lands in the result register.
    a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take && beat.last_byte |=> out_valid_reg)
        else $error("last beat consumed without a result");

    // The parser only consumes a beat that is actually held.
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> beat_valid)
        else $error("parser consumed an empty input register");

    a_ping_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_result_reg.touch_kind || out_result_reg.source_is_v6)
            |-> out_result_reg.hit)
        else $error("result qualifiers set without a hit");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_result_reg.hit
            |-> out_result_reg.dest_port == 16'd0 && out_result_reg.source_high == 64'd0
                && out_result_reg.source_low == 64'd0)
        else $error("non-hit result carries data");

endmodule

FILE: hdl/ipspc_in_stage.sv
module ipspc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ipspc_pkg::in_beat_t in_beat,
    input  logic                sink_free,
    output logic                take,
    output logic                beat_valid,
    output ipspc_pkg::in_beat_t beat
);
    import ipspc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    // A beat that is not the last one only updates the parser state, so it
    // never waits for the result register.
    assign take       = valid_reg && (!beat_reg.last_byte || sink_free);
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_valid || (valid_reg && !take);
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

FILE: hdl/ipspc_parser.sv
module ipspc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  ipspc_pkg::in_beat_t beat,
    output ipspc_pkg::result_t  verdict
);
    import ipspc_pkg::*;

    logic [OFFSET_W-1:0] offset_reg;
    logic [7:0]          first_reg;
    logic [15:0]         frag_reg;
    logic [7:0]          proto_reg;
    logic [63:0]         src0_reg;
    logic [63:0]         src1_reg;
    logic [15:0]         port_reg;
    logic [7:0]          flags_reg;
    logic [7:0]          icmp_reg;
    logic [1:0]          fam_reg;

    logic [OFFSET_W-1:0] offset_next;
    logic [7:0]          first_next;
    logic [15:0]         frag_next;
    logic [7:0]          proto_next;
    logic [63:0]         src0_next;
    logic [63:0]         src1_next;
    logic [15:0]         port_next;
    logic [7:0]          flags_next;
    logic [7:0]          icmp_next;
    logic [1:0]          fam_next;

    logic [OFFSET_W-1:0] off;
    logic [7:0]          b;
    logic [OFFSET_W-1:0] base;
    logic [OFFSET_W:0]   len;
    logic [OFFSET_W:0]   ihl;
    logic                is_v4;
    logic                is_v6;
    logic                v4_ok;
    logic                v6_ok;
    logic                syn_ok;
    logic                hit;
    logic                ping;

    assign off = offset_reg;
    assign b   = beat.packet_byte;

    // Captures for the current beat; the verdict sees these updated values.
    always_comb
    begin
        first_next = (off == '0) ? b : first_reg;
        fam_next   = (off == '0) ? beat.family : fam_reg;
        is_v4      = (fam_next == FAM_IPV4);
        is_v6      = (fam_next == FAM_IPV6);
        base       = is_v4 ? {1'b0, first_next[3:0], 2'b00} : V6_TRANSPORT_BASE;

        frag_next  = frag_reg;
        proto_next = proto_reg;
        src0_next  = src0_reg;
        src1_next  = src1_reg;
        port_next  = port_reg;
        flags_next = flags_reg;
        icmp_next  = icmp_reg;

        if (off == OFF_FRAG_HI || off == OFF_FRAG_LO)
        begin
            frag_next = {frag_reg[7:0], b};
        end
        if ((is_v4 && off == OFF_V4_PROTO) || (is_v6 && off == OFF_V6_NEXT))
        begin
            proto_next = b;
        end
        if (is_v4 && off >= OFF_V4_SRC_LO && off <= OFF_V4_SRC_HI)
        begin
            src1_next = {32'd0, src1_reg[23:0], b};
        end
        if (is_v6 && off >= OFF_V6_SRC0_LO && off <= OFF_V6_SRC0_HI)
        begin
            src0_next = {src0_reg[55:0], b};
        end
        if (is_v6 && off >= OFF_V6_SRC1_LO && off <= OFF_V6_SRC1_HI)
        begin
            src1_next = {src1_reg[55:0], b};
        end
        if (off == base)
        begin
            icmp_next = b;
        end
        if (off == base + TP_PORT_HI || off == base + TP_PORT_LO)
        begin
            port_next = {port_reg[7:0], b};
        end
        if (off == base + TP_FLAGS)
        begin
            flags_next = b;
        end

        offset_next = (off < OFFSET_MAX) ? off + 7'd1 : off;
    end

    // Verdict on the last beat of the packet.
    always_comb
    begin
        len    = {1'b0, off} + 8'd1;
        ihl    = {2'b00, first_next[3:0], 2'b00};
        syn_ok = (({1'b0, base} + {1'b0, TP_FLAGS}) < len)
              && ((flags_next & TCP_SYN_ACK_MASK) == TCP_SYN_ONLY);
        v4_ok  = is_v4 && first_next[7:4] == VERSION_V4 && ihl >= V4_MIN_IHL
              && ihl <= len && len >= V4_MIN_LEN
              && (frag_next & FRAG_OFFSET_MASK) == 16'd0;
        v6_ok  = is_v6 && first_next[7:4] == VERSION_V6 && len >= V6_MIN_LEN;
        hit    = 1'b0;
        ping   = 1'b0;
        if (v4_ok)
        begin
            if (proto_next == PROTO_TCP)
            begin
                hit = syn_ok;
            end
            else if (proto_next == PROTO_ICMP)
            begin
                hit  = ({1'b0, base} < len) && icmp_next == ICMP_ECHO_REQ;
                ping = hit;
            end
        end
        else if (v6_ok)
        begin
            if (proto_next == PROTO_TCP)
            begin
                hit = syn_ok;
            end
            else if (proto_next == PROTO_ICMPV6)
            begin
                hit  = ({1'b0, base} < len) && icmp_next == ICMPV6_ECHO_REQ;
                ping = hit;
            end
        end

        verdict.hit          = hit;
        verdict.touch_kind   = ping;
        verdict.dest_port    = (hit && !ping) ? port_next : 16'd0;
        verdict.source_is_v6 = hit && is_v6;
        verdict.source_high  = (hit && is_v6) ? src0_next : 64'd0;
        verdict.source_low   = !hit  ? 64'd0 :
                               is_v6 ? src1_next : {32'd0, src1_next[31:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            first_reg  <= '0;
            frag_reg   <= '0;
            proto_reg  <= '0;
            src0_reg   <= '0;
            src1_reg   <= '0;
            port_reg   <= '0;
            flags_reg  <= '0;
            icmp_reg   <= '0;
            fam_reg    <= '0;
        end
        else if (take)
        begin
            if (beat.last_byte)
            begin
                offset_reg <= '0;
                first_reg  <= '0;
                frag_reg   <= '0;
                proto_reg  <= '0;
                src0_reg   <= '0;
                src1_reg   <= '0;
                port_reg   <= '0;
                flags_reg  <= '0;
                icmp_reg   <= '0;
                fam_reg    <= '0;
            end
            else
            begin
                offset_reg <= offset_next;
                first_reg  <= first_next;
                frag_reg   <= frag_next;
                proto_reg  <= proto_next;
                src0_reg   <= src0_next;
                src1_reg   <= src1_next;
                port_reg   <= port_next;
                flags_reg  <= flags_next;
                icmp_reg   <= icmp_next;
                fam_reg    <= fam_next;
            end
        end
    end

endmodule
